// ===== rtl/ttr_pkg.sv =====
// ----------------------------------------------------------------------------
// ttr_pkg
// Shared types and constants of the triggered trace ring recorder: ring
// geometry, item kinds, register indexes and the stored record layout.
// ----------------------------------------------------------------------------
package ttr_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 1024;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = PTR_W + 1;

  // Fixed field widths
  localparam int KIND_W    = 3;
  localparam int OFF_W     = 10;
  localparam int COUNT_W   = 11;
  localparam int TIME_W    = 32;
  localparam int FLAG_W    = 8;
  localparam int PAYLOAD_W = 64;

  // Width that holds oldest+offset and the count side by side
  localparam int IDX_W = ((PTR_W > OFF_W) ? PTR_W : OFF_W) + 1;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE  = 3'd0,
    KIND_ENGAGE  = 3'd1,
    KIND_CONTROL = 3'd2,
    KIND_COUNT   = 3'd3,
    KIND_ENTRY   = 3'd4
  } kind_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUTO_START = 1'd0,
    CFG_AUTO_STOP  = 1'd1
  } cfg_reg_t;

  // One stored trace record
  typedef struct packed {
    logic [TIME_W-1:0]    stamp;
    logic [FLAG_W-1:0]    flags;
    logic [PAYLOAD_W-1:0] payload;
  } record_t;

  localparam int RECORD_W = $bits(record_t);

endpackage

// ===== rtl/ttr_item_if.sv =====
// ----------------------------------------------------------------------------
// ttr_item_if / ttr_result_if
// Valid/ready channels of the trace recorder: one for input items and one for
// result items.
// ----------------------------------------------------------------------------
interface ttr_item_if
  import ttr_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [3:0]           sat_state;
  logic [1:0]           footpad_state;
  logic                 wheelslip;
  logic                 running;
  logic [TIME_W-1:0]    timestamp;
  logic [PAYLOAD_W-1:0] payload;
  logic                 switch_on;
  logic [OFF_W-1:0]     offset;

  modport source (
    output valid, kind, sat_state, footpad_state, wheelslip, running,
           timestamp, payload, switch_on, offset,
    input  ready
  );
  modport sink (
    input  valid, kind, sat_state, footpad_state, wheelslip, running,
           timestamp, payload, switch_on, offset,
    output ready
  );
endinterface

interface ttr_result_if
  import ttr_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [COUNT_W-1:0]   record_count;
  logic                 entry_valid;
  logic [TIME_W-1:0]    entry_time;
  logic [FLAG_W-1:0]    entry_flags;
  logic [PAYLOAD_W-1:0] entry_payload;
  logic                 is_recording;

  modport source (
    output valid, record_count, entry_valid, entry_time, entry_flags,
           entry_payload, is_recording,
    input  ready
  );
  modport sink (
    input  valid, record_count, entry_valid, entry_time, entry_flags,
           entry_payload, is_recording,
    output ready
  );
endinterface

// ===== rtl/ttr_ram.sv =====
// ----------------------------------------------------------------------------
// ttr_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ttr_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/triggered_trace_ring_recorder.sv =====
// ----------------------------------------------------------------------------
// triggered_trace_ring_recorder
// Trace recorder over a ring of RING_DEPTH records that overwrites the
// oldest record when full.
// ----------------------------------------------------------------------------
// Usage:
//   item   : input beats. Samples are stored while recording; control beats and
//            engage beats (if enabled) start it, clearing the ring, or stop it.
//   result : a beat per count read (which stops recording) or entry read only.
//   cfg_we/cfg_index/cfg_data : write auto_start (index 0), auto_stop (1).
// Timing:
//   Sample, engage and control beats give no result and do not hold off the
//   next item; the ring RAM is written at the accepting edge. A count read
//   shows its result in the cycle after acceptance. An entry read passes the
//   RAM read register, then the output register; no item is taken meanwhile.
// Reset (rst, synchronous): ring empty, pointers zero, recording off,
//   auto_start and auto_stop set. The RAM itself is not cleared.
// Stall: a result waits in the output register; while it waits, no further
//   item is taken until the receiver takes it (ready may accept in the same
//   cycle the result leaves).
// ----------------------------------------------------------------------------
module triggered_trace_ring_recorder
  import ttr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  ttr_item_if.sink             item,
  ttr_result_if.source         result
);

  // Ring control state
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] old_ptr;
  logic             ring_empty;
  logic             recording;
  logic             auto_start;
  logic             auto_stop;

  // Entry read in flight
  logic               rd_pend;
  logic [COUNT_W-1:0] pend_count;
  logic               pend_valid;
  logic               pend_rec;

  // Output register
  logic               out_valid;
  logic [COUNT_W-1:0] out_count;
  logic               out_entry_valid;
  record_t            out_rec;
  logic               out_rec_flag;

  // Combinational values
  logic             accept;
  kind_t            kind;
  logic [IDX_W-1:0] count_w;
  logic [IDX_W-1:0] diff;
  logic [IDX_W-1:0] idx_sum;
  logic [IDX_W-1:0] idx_wrap;
  logic             off_ok;
  logic [PTR_W-1:0] wr_ptr_inc;
  logic [PTR_W-1:0] old_ptr_inc;
  logic             ram_we;
  logic             ram_re;
  logic [PTR_W-1:0] ram_raddr;
  record_t          wr_rec;
  record_t          rd_rec;

  assign kind   = kind_t'(item.kind);
  assign item.ready = !rd_pend && (!out_valid || result.ready);
  assign accept = item.valid && item.ready;

  // Pointer advance with wrap at the ring depth
  assign wr_ptr_inc  = (wr_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign old_ptr_inc = (old_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : old_ptr + 1'b1;

  // Record count: modular distance, a full ring reads as the depth
  always_comb begin
    if (wr_ptr >= old_ptr) begin
      diff = IDX_W'(wr_ptr) - IDX_W'(old_ptr);
    end else begin
      diff = IDX_W'(wr_ptr) + IDX_W'(RING_DEPTH) - IDX_W'(old_ptr);
    end
    if (ring_empty) begin
      count_w = '0;
    end else if (diff == '0) begin
      count_w = IDX_W'(RING_DEPTH);
    end else begin
      count_w = diff;
    end
  end

  // Entry address: oldest + offset, one wrap at most for valid offsets
  assign off_ok   = IDX_W'(item.offset) < count_w;
  assign idx_sum  = IDX_W'(old_ptr) + IDX_W'(item.offset);
  assign idx_wrap = (idx_sum >= IDX_W'(RING_DEPTH)) ?
                    idx_sum - IDX_W'(RING_DEPTH) : idx_sum;
  assign ram_raddr = idx_wrap[PTR_W-1:0];

  // Build the record of a sample
  assign wr_rec.stamp   = item.timestamp;
  assign wr_rec.flags   = {item.sat_state, item.footpad_state, item.wheelslip,
                           item.running};
  assign wr_rec.payload = item.payload;

  assign ram_we = accept && (kind == KIND_SAMPLE) && recording;
  assign ram_re = accept && (kind == KIND_ENTRY);

  ttr_ram #(
    .DEPTH (RING_DEPTH),
    .WIDTH (RECORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (wr_rec),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_rec)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      auto_start <= 1'b1;
      auto_stop  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_AUTO_START: auto_start <= cfg_data;
        CFG_AUTO_STOP:  auto_stop  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Ring pointers and recording state
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      old_ptr    <= '0;
      ring_empty <= 1'b1;
      recording  <= 1'b0;
    end else if (accept) begin
      unique case (kind)
        KIND_SAMPLE: begin
          if (recording) begin
            if (!ring_empty && (wr_ptr == old_ptr)) begin
              old_ptr <= old_ptr_inc;
            end
            wr_ptr     <= wr_ptr_inc;
            ring_empty <= 1'b0;
          end
        end
        KIND_ENGAGE: begin
          if (auto_start && item.switch_on) begin
            wr_ptr     <= '0;
            old_ptr    <= '0;
            ring_empty <= 1'b1;
            recording  <= 1'b1;
          end else if (auto_stop && !item.switch_on) begin
            recording <= 1'b0;
          end
        end
        KIND_CONTROL: begin
          if (item.switch_on) begin
            wr_ptr     <= '0;
            old_ptr    <= '0;
            ring_empty <= 1'b1;
            recording  <= 1'b1;
          end else begin
            recording <= 1'b0;
          end
        end
        KIND_COUNT: recording <= 1'b0;
        KIND_ENTRY: ;
        default: ;
      endcase
    end
  end

  // Hold entry-read side values while the RAM read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      pend_count <= count_w[COUNT_W-1:0];
      pend_valid <= off_ok;
      pend_rec   <= recording;
    end
  end

  // Output valid: set on a result, drop when the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_pend || (accept && (kind == KIND_COUNT))) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (rd_pend) begin
      out_count       <= pend_count;
      out_entry_valid <= pend_valid;
      out_rec         <= pend_valid ? rd_rec : '0;
      out_rec_flag    <= pend_rec;
    end else if (accept && (kind == KIND_COUNT)) begin
      out_count       <= count_w[COUNT_W-1:0];
      out_entry_valid <= 1'b0;
      out_rec         <= '0;
      out_rec_flag    <= 1'b0;
    end
  end

  assign result.valid         = out_valid;
  assign result.record_count  = out_count;
  assign result.entry_valid   = out_entry_valid;
  assign result.entry_time    = out_rec.stamp;
  assign result.entry_flags   = out_rec.flags;
  assign result.entry_payload = out_rec.payload;
  assign result.is_recording  = out_rec_flag;

endmodule
